// ===== src/positional_stereo_gain_macros.svh =====
// assertion macros shared by the checker files
// depends on nothing; expects a clock i_clk and an active-low reset i_rst_n in scope
`ifndef POSITIONAL_STEREO_GAIN_MACROS_SVH
`define POSITIONAL_STEREO_GAIN_MACROS_SVH

// checked only outside reset
`define PSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define PSG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/psg_pkg.sv =====
// shared widths and constants of the positional stereo gain pipeline
// no dependencies
package psg_pkg;
    localparam int POS_W    = 32;
    localparam int VEC_W    = 16;
    localparam int FALL_W   = 24;
    localparam int GAIN_W   = 16;
    localparam int IN_W     = 6 * POS_W + 6 * VEC_W;
    localparam int OFS_W    = POS_W + 1;
    localparam int ROOT_W   = 33;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int CRS_W    = 22;
    localparam int QP_W     = OFS_W + CRS_W;
    localparam int Q_W      = QP_W + 2;
    localparam int SHR_W    = 41;
    localparam int PROD_W   = ROOT_W + FALL_W;
    localparam int WIDE_W   = 82;
    localparam logic [SHR_W-1:0] ONE_Q40  = 41'h100_0000_0000;
    localparam logic [SHR_W-1:0] HALF_Q40 = 41'h080_0000_0000;
    localparam logic [FALL_W-1:0] FALLOFF_RESET = 24'd167772;
endpackage

// ===== src/psg_front.sv =====
// front stages: offset, squared length, left axis, projection and pan share
// depends on psg_pkg
module psg_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [psg_pkg::IN_W-1:0]          i_data,
    input  logic [psg_pkg::FALL_W-1:0]        i_falloff,
    output logic                              o_valid,
    output logic [psg_pkg::RAD_W-1:0]         o_rad,
    output logic [psg_pkg::SHR_W-1:0]         o_pan
);
    localparam int NST = 8;

    logic [NST-1:0] r_v;

    // stage 1
    logic signed [psg_pkg::OFS_W-1:0]   r_d1 [3];
    logic signed [2*psg_pkg::VEC_W-1:0] r_pa [3];
    logic signed [2*psg_pkg::VEC_W-1:0] r_pb [3];
    // stage 2
    logic signed [psg_pkg::OFS_W-1:0]   r_d2 [3];
    logic        [psg_pkg::RAD_W-1:0]   r_sq [3];
    logic signed [psg_pkg::CRS_W-1:0]   r_c  [3];
    // stage 3
    logic        [psg_pkg::RAD_W-1:0]   r_rad3;
    logic signed [psg_pkg::QP_W-1:0]    r_qp [3];
    // stages 4 to 8
    logic        [psg_pkg::RAD_W-1:0]   r_rad4, r_rad5, r_rad6, r_rad7, r_rad8;
    logic signed [psg_pkg::Q_W-1:0]     r_q4;
    logic        [psg_pkg::Q_W-1:0]     r_mq5;
    logic                               r_neg5, r_neg6, r_neg7;
    logic        [55:0]                 r_plo6;
    logic        [48:0]                 r_phi6;
    logic        [56:0]                 r_t7;
    logic        [psg_pkg::SHR_W-1:0]   r_pan8;

    logic signed [psg_pkg::POS_W-1:0]   w_src [3];
    logic signed [psg_pkg::POS_W-1:0]   w_lst [3];
    logic signed [psg_pkg::VEC_W-1:0]   w_fa  [3];
    logic signed [psg_pkg::VEC_W-1:0]   w_up  [3];
    logic        [psg_pkg::OFS_W-1:0]   w_mag [3];
    logic signed [psg_pkg::OFS_W-1:0]   w_dif [3];
    logic signed [psg_pkg::OFS_W:0]     w_rnd [3];
    logic        [psg_pkg::WIDE_W-1:0]  w_p;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_src[i] = i_data[psg_pkg::POS_W*i +: psg_pkg::POS_W];
            w_lst[i] = i_data[3*psg_pkg::POS_W + psg_pkg::POS_W*i +: psg_pkg::POS_W];
            w_fa[i]  = i_data[6*psg_pkg::POS_W + psg_pkg::VEC_W*i +: psg_pkg::VEC_W];
            w_up[i]  = i_data[6*psg_pkg::POS_W + 3*psg_pkg::VEC_W + psg_pkg::VEC_W*i
                              +: psg_pkg::VEC_W];
            w_mag[i] = r_d1[i][psg_pkg::OFS_W-1] ? psg_pkg::OFS_W'(-r_d1[i])
                                                 : psg_pkg::OFS_W'(r_d1[i]);
            w_dif[i] = psg_pkg::OFS_W'(r_pa[i]) - psg_pkg::OFS_W'(r_pb[i]);
            // round to nearest, ties upward, then drop 12 fraction bits
            w_rnd[i] = (psg_pkg::OFS_W+1)'(w_dif[i]) + (psg_pkg::OFS_W+1)'(2048);
        end
        w_p = {r_phi6, 32'd0} + psg_pkg::WIDE_W'(r_plo6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d1[i] <= (psg_pkg::OFS_W)'(w_src[i]) - (psg_pkg::OFS_W)'(w_lst[i]);
            end
            r_pa[0] <= w_up[1] * w_fa[2];
            r_pb[0] <= w_up[2] * w_fa[1];
            r_pa[1] <= w_up[2] * w_fa[0];
            r_pb[1] <= w_up[0] * w_fa[2];
            r_pa[2] <= w_up[0] * w_fa[1];
            r_pb[2] <= w_up[1] * w_fa[0];
            for (int i = 0; i < 3; i++) begin
                r_d2[i] <= r_d1[i];
                r_sq[i] <= psg_pkg::RAD_W'(w_mag[i]) * psg_pkg::RAD_W'(w_mag[i]);
                r_c[i]  <= w_rnd[i][psg_pkg::OFS_W -: psg_pkg::CRS_W];
                r_qp[i] <= psg_pkg::QP_W'(r_d2[i]) * psg_pkg::QP_W'(r_c[i]);
            end
            r_rad3 <= r_sq[0] + r_sq[1] + r_sq[2];
            r_rad4 <= r_rad3;
            r_q4   <= psg_pkg::Q_W'(r_qp[0]) + psg_pkg::Q_W'(r_qp[1])
                      + psg_pkg::Q_W'(r_qp[2]);
            r_rad5 <= r_rad4;
            r_neg5 <= r_q4[psg_pkg::Q_W-1];
            r_mq5  <= r_q4[psg_pkg::Q_W-1] ? psg_pkg::Q_W'(-r_q4) : psg_pkg::Q_W'(r_q4);
            r_rad6 <= r_rad5;
            r_neg6 <= r_neg5;
            r_plo6 <= 56'(r_mq5[31:0]) * 56'(i_falloff);
            r_phi6 <= 49'(r_mq5[psg_pkg::Q_W-1:32]) * 49'(i_falloff);
            r_rad7 <= r_rad6;
            r_neg7 <= r_neg6;
            // pan term saturates at one
            r_t7   <= (w_p[psg_pkg::WIDE_W-1:56] != '0) ? {1'b1, 56'd0}
                                                        : {1'b0, w_p[55:0]};
            r_rad8 <= r_rad7;
            r_pan8 <= r_neg7 ? psg_pkg::HALF_Q40 - psg_pkg::SHR_W'(r_t7[56:17])
                             : psg_pkg::HALF_Q40 + psg_pkg::SHR_W'(r_t7[56:17]);
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_rad   = r_rad8;
    assign o_pan   = r_pan8;
endmodule

// ===== src/psg_isqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on psg_pkg; carries a side payload alongside
module psg_isqrt #(
    parameter int PAY_W = 41
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [psg_pkg::RAD_W-1:0]     i_rad,
    input  logic [PAY_W-1:0]              i_pay,
    output logic                          o_valid,
    output logic [psg_pkg::ROOT_W-1:0]    o_root,
    output logic [PAY_W-1:0]              o_pay
);
    localparam int N     = psg_pkg::ROOT_W;
    localparam int REM_W = N + 3;

    logic [N-1:0]                   r_v;
    logic [psg_pkg::RAD_W-1:0]      r_rad  [N];
    logic [REM_W-1:0]               r_rem  [N];
    logic [N-1:0]                   r_root [N];
    logic [PAY_W-1:0]               r_pay  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                       w_vin;
        logic [psg_pkg::RAD_W-1:0]  w_rad;
        logic [REM_W-1:0]           w_rem, w_acc, w_trial;
        logic [N-1:0]               w_root;
        logic [PAY_W-1:0]           w_pay;

        if (k == 0) begin : g_first
            assign w_vin  = i_valid;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_pay  = i_pay;
        end else begin : g_next
            assign w_vin  = r_v[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_pay  = r_pay[k-1];
        end

        assign w_acc   = {w_rem[REM_W-3:0], w_rad[psg_pkg::RAD_W-1 -: 2]};
        assign w_trial = REM_W'({w_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= {w_rad[psg_pkg::RAD_W-3:0], 2'b00};
                r_pay[k] <= w_pay;
                if (w_acc >= w_trial) begin
                    r_rem[k]  <= w_acc - w_trial;
                    r_root[k] <= {w_root[N-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_acc;
                    r_root[k] <= {w_root[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_pay   = r_pay[N-1];
endmodule

// ===== src/psg_gain.sv =====
// back stages: distance factor and the two rounded channel gains
// depends on psg_pkg
module psg_gain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [psg_pkg::ROOT_W-1:0]    i_root,
    input  logic [psg_pkg::SHR_W-1:0]     i_pan,
    input  logic [psg_pkg::FALL_W-1:0]    i_falloff,
    output logic                          o_valid,
    output logic                          o_audible,
    output logic [psg_pkg::GAIN_W-1:0]    o_left,
    output logic [psg_pkg::GAIN_W-1:0]    o_right
);
    localparam int HI_W = psg_pkg::SHR_W - 20;

    logic [3:0]                   r_v;
    logic [psg_pkg::PROD_W-1:0]   r_prod1;
    logic [psg_pkg::SHR_W-1:0]    r_pan1;
    logic                         r_aud2, r_aud3, r_aud4;
    logic [psg_pkg::SHR_W-1:0]    r_f2, r_pl2, r_pr2;
    logic [2*HI_W-1:0]            r_hh [2];
    logic [HI_W+19:0]             r_hl [2];
    logic [HI_W+19:0]             r_lh [2];
    logic [39:0]                  r_ll [2];
    logic [psg_pkg::GAIN_W-1:0]   r_left4, r_right4;

    logic [psg_pkg::SHR_W-1:0]    w_sh  [2];
    logic [psg_pkg::WIDE_W-1:0]   w_sum [2];
    logic [18:0]                  w_rnd [2];
    logic                         w_aud;

    always_comb begin
        w_sh[0] = r_pl2;
        w_sh[1] = r_pr2;
        w_aud   = (r_prod1[psg_pkg::PROD_W-1:40] == '0);
        for (int i = 0; i < 2; i++) begin
            w_sum[i] = {r_hh[i], 40'd0} + psg_pkg::WIDE_W'({r_hl[i], 20'd0})
                       + psg_pkg::WIDE_W'({r_lh[i], 20'd0}) + psg_pkg::WIDE_W'(r_ll[i]);
            // round half up from the 2^-15 step
            w_rnd[i] = 19'(w_sum[i][psg_pkg::WIDE_W-1:64]) + 19'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= psg_pkg::PROD_W'(i_root) * psg_pkg::PROD_W'(i_falloff);
            r_pan1  <= i_pan;
            r_aud2  <= w_aud;
            r_f2    <= psg_pkg::ONE_Q40 - {1'b0, r_prod1[39:0]};
            r_pl2   <= r_pan1;
            r_pr2   <= psg_pkg::ONE_Q40 - r_pan1;
            r_aud3  <= r_aud2;
            for (int i = 0; i < 2; i++) begin
                r_hh[i] <= (2*HI_W)'(w_sh[i][psg_pkg::SHR_W-1:20])
                           * (2*HI_W)'(r_f2[psg_pkg::SHR_W-1:20]);
                r_hl[i] <= (HI_W+20)'(w_sh[i][psg_pkg::SHR_W-1:20]) * (HI_W+20)'(r_f2[19:0]);
                r_lh[i] <= (HI_W+20)'(w_sh[i][19:0]) * (HI_W+20)'(r_f2[psg_pkg::SHR_W-1:20]);
                r_ll[i] <= 40'(w_sh[i][19:0]) * 40'(r_f2[19:0]);
            end
            r_aud4   <= r_aud3;
            r_left4  <= r_aud3 ? w_rnd[0][16:1] : '0;
            r_right4 <= r_aud3 ? w_rnd[1][16:1] : '0;
        end
    end

    assign o_valid   = r_v[3];
    assign o_audible = r_aud4;
    assign o_left    = r_left4;
    assign o_right   = r_right4;
endmodule

// ===== src/positional_stereo_gain.sv =====
// positional stereo gain: a fully pipelined unit that takes a source position and a
// listener pose and returns left and right gains. one transaction enters per cycle unless
// the output stalls, and runs through 8 front stages (offset, squares, left axis, pan),
// 33 square-root stages (one root bit each, which set most of the latency) and 4 gain
// stages. the whole pipe holds when the output transaction is stalled. the falloff
// register may only be written while no transaction is in flight.
// depends on psg_pkg, psg_front, psg_isqrt, psg_gain
module positional_stereo_gain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // falloff register, unsigned q0.24
    input  logic                          i_cfg_we,
    input  logic [psg_pkg::FALL_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // source_x, source_y, source_z, listener_x, listener_y, listener_z (32 bit each),
    // facing_x, facing_y, facing_z, up_x, up_y, up_z (16 bit each), lowest bit first
    input  logic [psg_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // left_gain [15:0], right_gain [31:16]
    output logic [2*psg_pkg::GAIN_W-1:0]  m_axis_tdata,
    // audible
    output logic                          m_axis_tuser
);
    logic [psg_pkg::FALL_W-1:0]  r_falloff;
    logic                        w_en;
    logic                        w_fr_valid, w_sq_valid;
    logic [psg_pkg::RAD_W-1:0]   w_rad;
    logic [psg_pkg::SHR_W-1:0]   w_pan, w_sq_pan;
    logic [psg_pkg::ROOT_W-1:0]  w_root;
    logic [psg_pkg::GAIN_W-1:0]  w_left, w_right;

    // the pipe moves whenever the output slot is free or being taken
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falloff <= psg_pkg::FALLOFF_RESET;
        end else if (i_cfg_we) begin
            r_falloff <= i_cfg_wdata;
        end
    end

    // offset, squared length and pan share
    psg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_falloff (r_falloff),
        .o_valid   (w_fr_valid),
        .o_rad     (w_rad),
        .o_pan     (w_pan)
    );

    // distance, with the pan share riding alongside
    psg_isqrt #(
        .PAY_W (psg_pkg::SHR_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_rad   (w_rad),
        .i_pay   (w_pan),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_pay   (w_sq_pan)
    );

    // distance factor and rounded gains; its last stage is the output register
    psg_gain u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_sq_valid),
        .i_root    (w_root),
        .i_pan     (w_sq_pan),
        .i_falloff (r_falloff),
        .o_valid   (m_axis_tvalid),
        .o_audible (m_axis_tuser),
        .o_left    (w_left),
        .o_right   (w_right)
    );

    assign m_axis_tdata = {w_right, w_left};
endmodule

// ===== src/psg_checker.sv =====
// port-level checks on the positional stereo gain block, bound to the top level
// depends on psg_pkg and positional_stereo_gain_macros.svh
`include "positional_stereo_gain_macros.svh"

module psg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [2*psg_pkg::GAIN_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser
);
    logic [psg_pkg::GAIN_W:0] w_gsum;
    logic                     w_stall;
    assign w_gsum = (psg_pkg::GAIN_W+1)'(m_axis_tdata[psg_pkg::GAIN_W-1:0])
                    + (psg_pkg::GAIN_W+1)'(m_axis_tdata[2*psg_pkg::GAIN_W-1:psg_pkg::GAIN_W]);
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    `PSG_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `PSG_ASSERT(a_mute_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "mute gain")
    `PSG_ASSERT(a_gain_sum, m_axis_tvalid |-> (w_gsum <= 17'd32769), "gain sum above unity")
    `PSG_ASSERT(a_hold, w_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
endmodule

bind positional_stereo_gain psg_checker u_psg_checker (.*);

// ===== tb/tb_positional_stereo_gain.sv =====
// self-checking testbench for positional_stereo_gain: directed and random source/listener
// poses under several falloff settings, every result checked against an in-bench predictor
// depends on psg_pkg and the positional_stereo_gain rtl
`timescale 1ns / 100ps

module tb_positional_stereo_gain;

    localparam logic [127:0] ONE40  = 128'h1 << 40;
    localparam logic [127:0] HALF40 = 128'h1 << 39;
    localparam logic [127:0] ONE56  = 128'h1 << 56;

    typedef struct packed {
        logic                       audible;
        logic [psg_pkg::GAIN_W-1:0] left_gain;
        logic [psg_pkg::GAIN_W-1:0] right_gain;
    } t_gain_pair;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [psg_pkg::FALL_W-1:0]    i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // source_x/y/z, listener_x/y/z (32 bit), facing_x/y/z, up_x/y/z (16 bit), lowest first
    logic [psg_pkg::IN_W-1:0]      s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // left_gain, right_gain, lowest first
    logic [2*psg_pkg::GAIN_W-1:0]  m_axis_tdata;
    // audible
    logic                          m_axis_tuser;

    // model copy of the falloff register
    logic [psg_pkg::FALL_W-1:0]    falloff_q;
    t_gain_pair                    gain_queue[$];
    int                            errors;
    int                            n_sent;
    int                            n_checked;
    int                            n_audible;
    bit                            quiet_stall;
    bit                            quiet_gap;

    positional_stereo_gain u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // expected gains of one pose, exact integer arithmetic at generous widths
    function automatic t_gain_pair predict_gains(logic [psg_pkg::IN_W-1:0] x,
                                                 logic [psg_pkg::FALL_W-1:0] fall);
        longint       ofs[3];
        longint       fac[3];
        longint       upv[3];
        longint       axis[3];
        longint       proj;
        logic [127:0] mg;
        logic [127:0] radicand;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] dist_prod;
        logic [127:0] factor;
        logic [127:0] pan;
        logic [127:0] share;
        logic [127:0] wide;
        t_gain_pair   r;
        for (int i = 0; i < 3; i++) begin
            ofs[i] = longint'($signed(x[32*i +: 32])) - longint'($signed(x[32*(i+3) +: 32]));
            fac[i] = longint'($signed(x[192 + 16*i +: 16]));
            upv[i] = longint'($signed(x[240 + 16*i +: 16]));
        end
        radicand = '0;
        for (int i = 0; i < 3; i++) begin
            mg = 128'((ofs[i] < 0) ? -ofs[i] : ofs[i]);
            radicand = radicand + mg * mg;
        end
        // bitwise integer square root, 35 root bits
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            trial = root | (128'h1 << b);
            if (trial * trial <= radicand) root = trial;
        end
        dist_prod = root * fall;
        r = '0;
        // too far away: silent
        if (dist_prod >= ONE40) return r;
        factor = ONE40 - dist_prod;
        // left axis up x facing, rounded q4.28 -> q4.16, ties upward
        axis[0] = (upv[1] * fac[2] - upv[2] * fac[1] + 2048) >>> 12;
        axis[1] = (upv[2] * fac[0] - upv[0] * fac[2] + 2048) >>> 12;
        axis[2] = (upv[0] * fac[1] - upv[1] * fac[0] + 2048) >>> 12;
        proj = ofs[0] * axis[0] + ofs[1] * axis[1] + ofs[2] * axis[2];
        mg = 128'((proj < 0) ? -proj : proj);
        pan = mg * fall;
        if (pan >= ONE56) pan = ONE56;
        share = (proj < 0) ? HALF40 - (pan >> 17) : HALF40 + (pan >> 17);
        r.audible = 1'b1;
        wide = share * factor;
        r.left_gain = 16'(((wide >> 64) + 1) >> 1);
        wide = (ONE40 - share) * factor;
        r.right_gain = 16'(((wide >> 64) + 1) >> 1);
        return r;
    endfunction

    function automatic logic [psg_pkg::IN_W-1:0] pack_pose(
        logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
        logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
        logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
        logic [15:0] ux, logic [15:0] uy, logic [15:0] uz);
        return {uz, uy, ux, fz, fy, fx, lz, ly, lx, sz, sy, sx};
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, n_checked, got, want);
        errors++;
    endtask

    // record the expectation of every input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            gain_queue.push_back(predict_gains(s_axis_tdata, falloff_q));
        end
    end

    // compare every output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_gain_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (gain_queue.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = gain_queue.pop_front();
                if (m_axis_tuser !== want.audible)
                    report_mismatch("audible", m_axis_tuser, want.audible);
                if (m_axis_tdata[15:0] !== want.left_gain)
                    report_mismatch("left_gain", m_axis_tdata[15:0], want.left_gain);
                if (m_axis_tdata[31:16] !== want.right_gain)
                    report_mismatch("right_gain", m_axis_tdata[31:16], want.right_gain);
                if (want.audible) n_audible++;
            end
            n_checked++;
        end
    end

    // output back-pressure: mostly short stalls, now and then a long one
    initial begin
        int hold;
        int r;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_stall) begin
                hold = 0;
                m_axis_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    hold = $urandom_range(20, 70);
                    m_axis_tready <= 1'b0;
                end else if (r < 25) begin
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // one input transaction, with a random gap ahead of it
    task automatic send_pose(logic [psg_pkg::IN_W-1:0] pose);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = quiet_gap ? 0 : (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pose;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (n_checked < n_sent) @(posedge i_clk);
        // pipe is 45 deep, let it settle
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_falloff(logic [psg_pkg::FALL_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        falloff_q = v;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_vec_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 16'sd16384;
        if (r < 6) return -16'sd16384;
        if (r < 8) return 16'd0;
        return 16'($urandom());
    endfunction

    // listener anywhere, source close by (or anywhere now and then)
    function automatic logic [psg_pkg::IN_W-1:0] rand_pose(int reach);
        logic [31:0] lp[3];
        logic [31:0] sp[3];
        logic [15:0] vc[6];
        for (int i = 0; i < 3; i++) begin
            lp[i] = $urandom();
            if ($urandom_range(0, 9) == 0) sp[i] = $urandom();
            else sp[i] = lp[i] + 32'($signed($urandom_range(0, 2*reach)) - reach);
        end
        for (int i = 0; i < 6; i++) vc[i] = rand_vec_comp();
        return pack_pose(sp[0], sp[1], sp[2], lp[0], lp[1], lp[2],
                         vc[0], vc[1], vc[2], vc[3], vc[4], vc[5]);
    endfunction

    // corner poses: zero offset, extreme positions and vectors, hard left and right
    task automatic test_directed();
        set_falloff(psg_pkg::FALLOFF_RESET);
        send_pose(pack_pose(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384));
        send_pose(pack_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000,
                            16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000));
        send_pose(pack_pose(32'h80000000, 0, 0, 32'h7fffffff, 0, 0,
                            16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
        send_pose(pack_pose(32'h00100000, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(32'hfff00000, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(0, 32'h00400000, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384));
        send_pose(pack_pose(0, 0, 32'h00630000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pose(pack_pose(0, 0, 32'h00650000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pose(pack_pose(32'h00010000, 32'hffff0000, 32'h00020000, 0, 0, 0,
                            16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        // zero falloff: unity factor, centred pan
        set_falloff(24'd0);
        send_pose(pack_pose(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 0, 0, 0,
                            16'h7fff, 16'h1234, 16'h8000, 16'h4000, 16'hc000, 16'h0001));
        // largest falloff: almost any distance is silent
        set_falloff(24'hffffff);
        send_pose(pack_pose(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384));
        send_pose(pack_pose(32'h0000ffff, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(32'h00000100, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(32'h00010000, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_pose(pack_pose(32'hffffff00, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        // short non-unit vectors
        send_pose(pack_pose(32'h00000800, 32'h00000400, 0, 0, 0, 0, 1, 2, 3, 16'hffff, 4, 5));
    endtask

    // random poses under one falloff setting
    task automatic test_random(logic [psg_pkg::FALL_W-1:0] fall, int count, int reach);
        set_falloff(fall);
        for (int i = 0; i < count; i++) begin
            quiet_gap   = (i % 100) >= 80;
            quiet_stall = (i % 150) >= 120;
            // one pause with every result home
            if (i == count / 2) wait_drained();
            send_pose(rand_pose(reach));
        end
        quiet_gap   = 1'b0;
        quiet_stall = 1'b0;
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_audible = 0;
        quiet_gap = 1'b0;
        quiet_stall = 1'b0;
        falloff_q = psg_pkg::FALLOFF_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the register, no write yet
        send_pose(pack_pose(32'h00200000, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        test_directed();
        test_random(psg_pkg::FALLOFF_RESET, 300, 32'h00800000);
        test_random(24'd0,         150, 32'h7fffffff);
        test_random(24'hffffff,    150, 32'h00010000);
        test_random(24'h010000,    200, 32'h01000000);
        test_random(24'($urandom()), 200, 32'h00400000);

        wait_drained();
        if (gain_queue.size() != 0) begin
            report_mismatch("results outstanding", gain_queue.size(), 0);
        end
        $display("covered %0d poses, %0d results checked (%0d audible), falloff from 0 to max",
                 n_sent, n_checked, n_audible);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", gain_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
